>>> hdl/swc_pkg.sv
// swc_pkg: shared widths, operation codes, register indexes and defaults
// for the sliding window correlation unit. No dependencies.
`timescale 1ns / 1ps

package swc_pkg;

    // payload widths
    localparam int OP_W       = 3;
    localparam int VALUE_W    = 16;
    localparam int INDEX_W    = 4;
    localparam int RESULT_W   = 32;

    // accumulator widths, sized for the largest history
    localparam int SUM_W      = 28;
    localparam int ACC_W      = 44;
    localparam int CNT_W      = 13;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int WL_W       = 13;
    localparam int VF_W       = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_FLOOR = 1'd1;

    localparam logic [WL_W-1:0] WL_RESET = 13'd1024;
    localparam logic [VF_W-1:0] VF_RESET = 16'd1;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_CORR  = 3'd1;
    localparam logic [OP_W-1:0] OP_COV   = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    // shared divider: dividend magnitude and divisor widths
    localparam int DIV_N      = 56;
    localparam int DEN_W      = 33;

    // parameter defaults
    localparam int DEF_NUM_PARAMS    = 8;
    localparam int DEF_HISTORY_DEPTH = 1024;
    localparam int DEF_MIN_WINDOW    = 16;

endpackage

>>> hdl/swc_ram.sv
// swc_ram: generic simple dual-port RAM, one write port and one read port
// with registered read data. No dependencies.
`timescale 1ns / 1ps

module swc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/sliding_window_correlation_unit.sv
// sliding_window_correlation_unit: windowed sums, covariance and correlation
// over vector samples. Depends on swc_pkg and swc_ram.
//
//  channel | direction | signals                                       | transfer
//  --------+-----------+-----------------------------------------------+------------------
//  cfg     | in        | cfg_write cfg_index cfg_data                  | cfg_write high
//  s       | in        | s_operation s_sample_value s_row/col_index    | s_valid & s_ready
//  m       | out       | m_read_value m_empty_window                   | m_valid & m_ready
//
// the push word that completes a sample starts one
// add pass over the sums memory, preceded by one subtract pass per evicted
// sample, each pass walking every sums entry, one sums entry per cycle
// a covariance read runs the one bit per cycle divider (56 steps) once; a
// correlation read runs it four times and the square root (32 steps) once
// count, empty and out of range reads skip to the output state; clear is done in idle
// reset is immediate: sums read as zero through per-entry valid bits
// s_ready is high only when idle; a finished word waits in the output
// register while the next word is accepted
`timescale 1ns / 1ps

module sliding_window_correlation_unit #(
    parameter int NUM_PARAMS    = swc_pkg::DEF_NUM_PARAMS,
    parameter int HISTORY_DEPTH = swc_pkg::DEF_HISTORY_DEPTH,
    parameter int MIN_WINDOW    = swc_pkg::DEF_MIN_WINDOW
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_write,
    input  logic [swc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [swc_pkg::OP_W-1:0]          s_operation,
    input  logic signed [swc_pkg::VALUE_W-1:0] s_sample_value,
    input  logic [swc_pkg::INDEX_W-1:0]       s_row_index,
    input  logic [swc_pkg::INDEX_W-1:0]       s_col_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [swc_pkg::RESULT_W-1:0] m_read_value,
    output logic                              m_empty_window
);

    import swc_pkg::*;

    localparam int EW     = $clog2(NUM_PARAMS);
    localparam int TRI    = NUM_PARAMS * (NUM_PARAMS + 1) / 2;
    localparam int SDEPTH = TRI + NUM_PARAMS;
    localparam int KW     = $clog2(SDEPTH);
    localparam int SLOTS  = HISTORY_DEPTH + 1;
    localparam int SW     = $clog2(SLOTS);
    localparam int RDEPTH = SLOTS * (1 << EW);
    localparam int DCW    = $clog2(DIV_N);
    localparam int NUM_W  = DIV_N + 2;
    localparam int Q_W    = DIV_N + 1;

    localparam logic signed [Q_W-1:0] CORR_ONE = Q_W'(16384);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_PASS, ST_DRAIN, ST_QREAD, ST_QMUL, ST_QDIVGO,
        ST_QDIV, ST_CMUL, ST_SQGO, ST_SQ, ST_CDIVGO, ST_CDIV, ST_OUT
    } state_t;

    typedef enum logic [1:0] {SEL_CROSS, SEL_ROW, SEL_COL} sel_t;

    // control registers
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SW-1:0]        oldest_reg, oldest_next;
    logic [SW-1:0]        nslot_reg, nslot_next;
    logic [EW-1:0]        elem_pos_reg, elem_pos_next;
    logic [WL_W-1:0]      wl_reg, wl_next;
    logic [VF_W-1:0]      vf_reg, vf_next;
    logic [SW-1:0]        pass_slot_reg, pass_slot_next;
    logic                 pass_neg_reg, pass_neg_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [EW-1:0]        i_reg, i_next;
    logic [EW-1:0]        j_reg, j_next;
    logic                 elem_phase_reg, elem_phase_next;
    logic                 drain_reg, drain_next;
    logic [1:0]           rd_cnt_reg, rd_cnt_next;
    sel_t                 q_stage_reg, q_stage_next;
    logic                 q_corr_reg, q_corr_next;
    logic [EW-1:0]        row_reg, row_next;
    logic [EW-1:0]        col_reg, col_next;
    logic signed [33:0]   c_reg, c_next;
    logic [31:0]          vi_reg, vi_next;
    logic [31:0]          vj_reg, vj_next;
    logic [31:0]          d_reg, d_next;
    logic [RESULT_W-1:0]  res_value_reg, res_value_next;
    logic                 res_empty_reg, res_empty_next;
    logic                 m_valid_reg, m_valid_next;
    logic [RESULT_W-1:0]  m_value_reg, m_value_next;
    logic                 m_empty_reg, m_empty_next;

    logic clear_pulse;
    logic div_start;
    logic sq_start;

    // memories
    logic                  ring_we;
    logic [SW+EW-1:0]      ring_waddr;
    logic [SW+EW-1:0]      ring_raddr;
    logic [VALUE_W-1:0]    ring_rdata;
    logic                  sum_we;
    logic [KW-1:0]         sum_waddr;
    logic [ACC_W-1:0]      sum_wdata;
    logic [KW-1:0]         sum_raddr;
    logic [ACC_W-1:0]      sum_rdata;
    logic [SDEPTH-1:0]     valid_reg;
    logic                  valid_q_reg;
    logic signed [ACC_W-1:0] sum_word;

    // pass pipeline
    logic                  s1_valid_reg, s1_diag_reg, s1_elem_reg, s1_neg_reg;
    logic [KW-1:0]         s1_addr_reg;
    logic                  s2_valid_reg, s2_neg_reg;
    logic [KW-1:0]         s2_addr_reg;
    logic signed [VALUE_W-1:0] a_reg;
    logic signed [VALUE_W-1:0] factor;
    logic signed [31:0]    prod_reg;
    logic signed [ACC_W-1:0] old_reg;

    // query datapath
    logic signed [SUM_W-1:0] sa_reg, sb_reg;
    logic signed [ACC_W-1:0] p_reg;
    logic signed [NUM_W-1:0] np_reg;
    logic signed [2*SUM_W-1:0] ss_reg;
    logic [2*CNT_W-2:0]     nn_reg;
    logic [63:0]            vv_reg;
    logic [EW-1:0]          qx, qy, qlo, qhi;
    logic [9:0]             tri_tmp;
    logic [KW-1:0]          tri_addr;

    // divider
    logic signed [NUM_W-1:0] div_num;
    logic [NUM_W-1:0]       div_mag_full;
    logic [DEN_W-1:0]       div_den;
    logic [DIV_N-1:0]       div_quo_reg;
    logic [DEN_W-1:0]       div_rem_reg;
    logic [DEN_W-1:0]       div_den_reg;
    logic                   div_neg_reg;
    logic                   div_busy_reg;
    logic [DCW-1:0]         div_cnt_reg;
    logic [DEN_W:0]         div_shift;
    logic                   div_ge;
    logic signed [Q_W-1:0]  q_ext;
    logic signed [Q_W-1:0]  div_q;

    // square root
    logic [63:0]            sq_v_reg, sq_res_reg, sq_bit_reg, sq_trial;

    // misc comb
    logic [WL_W-1:0]        lim;
    logic                   row_ok, col_ok;
    logic [VF_W-1:0]        fl_eff;
    logic signed [Q_W-1:0]  fl_ext;
    logic [31:0]            q_floored;
    logic [RESULT_W-1:0]    q_sat;
    logic [RESULT_W-1:0]    q_corr_val;
    logic                   pass_last;
    logic                   accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_read_value   = m_value_reg;
    assign m_empty_window = m_empty_reg;

    swc_ram #(.WIDTH(VALUE_W), .DEPTH(RDEPTH)) u_ring (
        .aclk (aclk),
        .we   (ring_we),
        .waddr(ring_waddr),
        .wdata(s_sample_value),
        .raddr(ring_raddr),
        .rdata(ring_rdata)
    );

    swc_ram #(.WIDTH(ACC_W), .DEPTH(SDEPTH)) u_sums (
        .aclk (aclk),
        .we   (sum_we),
        .waddr(sum_waddr),
        .wdata(sum_wdata),
        .raddr(sum_raddr),
        .rdata(sum_rdata)
    );

    assign ring_we    = accept && (s_operation == OP_PUSH);
    assign ring_waddr = {nslot_reg, elem_pos_reg};
    assign ring_raddr = {pass_slot_reg, elem_phase_reg ? i_reg : j_reg};

    assign sum_word = valid_q_reg ? $signed(sum_rdata) : '0;

    // query addressing
    always_comb begin
        qx = (q_stage_reg == SEL_COL) ? col_reg : row_reg;
        qy = (q_stage_reg == SEL_ROW) ? row_reg : col_reg;
        qlo = (qx < qy) ? qx : qy;
        qhi = (qx < qy) ? qy : qx;
        tri_tmp = ((10'(qlo) * (10'(2 * NUM_PARAMS - 1) - 10'(qlo))) >> 1) + 10'(qhi);
        tri_addr = tri_tmp[KW-1:0];
        case (rd_cnt_reg)
            2'd0:    sum_raddr = KW'(TRI) + KW'(qx);
            2'd1:    sum_raddr = KW'(TRI) + KW'(qy);
            2'd2:    sum_raddr = tri_addr;
            default: sum_raddr = tri_addr;
        endcase
        if (state_reg == ST_PASS) begin
            sum_raddr = k_reg;
        end
    end

    // pass pipeline and sums write back
    assign factor    = s1_diag_reg ? $signed(ring_rdata) : a_reg;
    assign sum_we    = s2_valid_reg;
    assign sum_waddr = s2_addr_reg;
    assign sum_wdata = s2_neg_reg ? ACC_W'(old_reg - ACC_W'(prod_reg))
                                  : ACC_W'(old_reg + ACC_W'(prod_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            valid_reg    <= '0;
        end else begin
            s1_valid_reg <= (state_reg == ST_PASS);
            s2_valid_reg <= s1_valid_reg;
            if (clear_pulse) begin
                valid_reg <= '0;
            end else if (sum_we) begin
                valid_reg[sum_waddr] <= 1'b1;
            end
        end
        valid_q_reg <= valid_reg[sum_raddr];
        s1_addr_reg <= k_reg;
        s1_diag_reg <= !elem_phase_reg && (i_reg == j_reg);
        s1_elem_reg <= elem_phase_reg;
        s1_neg_reg  <= pass_neg_reg;
        if (s1_diag_reg) begin
            a_reg <= $signed(ring_rdata);
        end
        prod_reg    <= s1_elem_reg ? 32'($signed(ring_rdata)) : factor * $signed(ring_rdata);
        old_reg     <= sum_word;
        s2_addr_reg <= s1_addr_reg;
        s2_neg_reg  <= s1_neg_reg;
    end

    // query operands and products
    always_ff @(posedge aclk) begin
        if (state_reg == ST_QREAD) begin
            case (rd_cnt_reg)
                2'd1:    sa_reg <= sum_word[SUM_W-1:0];
                2'd2:    sb_reg <= sum_word[SUM_W-1:0];
                2'd3:    p_reg  <= sum_word;
                default: ;
            endcase
        end
        if (state_reg == ST_QMUL) begin
            np_reg <= $signed({1'b0, count_reg}) * p_reg;
            ss_reg <= sa_reg * sb_reg;
            nn_reg <= count_reg * count_reg;
        end
        if (state_reg == ST_CMUL) begin
            vv_reg <= vi_reg * vj_reg;
        end
    end

    // shared divider, floor division by a positive divisor
    always_comb begin
        if (state_reg == ST_CDIVGO) begin
            div_num = (NUM_W'(c_reg) <<< 15) + $signed(NUM_W'(d_reg));
            div_den = {d_reg, 1'b0};
        end else begin
            div_num = np_reg - NUM_W'(ss_reg);
            div_den = DEN_W'(nn_reg);
        end
        div_mag_full = div_num[NUM_W-1] ? NUM_W'(-div_num) : NUM_W'(div_num);
        div_shift = {div_rem_reg, div_quo_reg[DIV_N-1]};
        div_ge    = div_shift >= {1'b0, div_den_reg};
        q_ext     = $signed({1'b0, div_quo_reg});
        if (!div_neg_reg) begin
            div_q = q_ext;
        end else if (div_rem_reg != '0) begin
            div_q = ~q_ext;
        end else begin
            div_q = -q_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
        end else if (div_start) begin
            div_busy_reg <= 1'b1;
        end else if (div_busy_reg && div_cnt_reg == DCW'(DIV_N - 1)) begin
            div_busy_reg <= 1'b0;
        end
        if (div_start) begin
            div_quo_reg <= div_mag_full[DIV_N-1:0];
            div_rem_reg <= '0;
            div_den_reg <= div_den;
            div_neg_reg <= div_num[NUM_W-1];
            div_cnt_reg <= '0;
        end else if (div_busy_reg) begin
            div_quo_reg <= {div_quo_reg[DIV_N-2:0], div_ge};
            div_rem_reg <= div_ge ? DEN_W'(div_shift - {1'b0, div_den_reg})
                                  : div_shift[DEN_W-1:0];
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // square root, two bits per cycle
    assign sq_trial = sq_res_reg + sq_bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_bit_reg <= '0;
        end else if (sq_start) begin
            sq_bit_reg <= 64'h4000_0000_0000_0000;
        end else if (sq_bit_reg != '0) begin
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (sq_start) begin
            sq_v_reg   <= vv_reg;
            sq_res_reg <= '0;
        end else if (sq_bit_reg != '0) begin
            if (sq_v_reg >= sq_trial) begin
                sq_v_reg   <= sq_v_reg - sq_trial;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end else begin
                sq_res_reg <= sq_res_reg >> 1;
            end
        end
    end

    // result shaping
    always_comb begin
        lim = (wl_reg < WL_W'(MIN_WINDOW)) ? WL_W'(MIN_WINDOW) : wl_reg;
        if (lim > WL_W'(HISTORY_DEPTH)) begin
            lim = WL_W'(HISTORY_DEPTH);
        end
        row_ok = {1'b0, s_row_index} < (INDEX_W + 1)'(NUM_PARAMS);
        col_ok = {1'b0, s_col_index} < (INDEX_W + 1)'(NUM_PARAMS);
        fl_eff = (vf_reg == '0) ? VF_W'(1) : vf_reg;
        fl_ext = $signed(Q_W'(fl_eff));
        q_floored = (div_q < fl_ext) ? 32'(fl_eff) : div_q[31:0];
        if (div_q[Q_W-1:RESULT_W-1] == '0 || div_q[Q_W-1:RESULT_W-1] == '1) begin
            q_sat = div_q[RESULT_W-1:0];
        end else if (div_q[Q_W-1]) begin
            q_sat = 32'h8000_0000;
        end else begin
            q_sat = 32'h7FFF_FFFF;
        end
        if (div_q > CORR_ONE) begin
            q_corr_val = RESULT_W'(CORR_ONE);
        end else if (div_q < -CORR_ONE) begin
            q_corr_val = RESULT_W'(-CORR_ONE);
        end else begin
            q_corr_val = div_q[RESULT_W-1:0];
        end
        pass_last = (k_reg == KW'(SDEPTH - 1));
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        oldest_next     = oldest_reg;
        nslot_next      = nslot_reg;
        elem_pos_next   = elem_pos_reg;
        wl_next         = wl_reg;
        vf_next         = vf_reg;
        pass_slot_next  = pass_slot_reg;
        pass_neg_next   = pass_neg_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        elem_phase_next = elem_phase_reg;
        drain_next      = drain_reg;
        rd_cnt_next     = rd_cnt_reg;
        q_stage_next    = q_stage_reg;
        q_corr_next     = q_corr_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        c_next          = c_reg;
        vi_next         = vi_reg;
        vj_next         = vj_reg;
        d_next          = d_reg;
        res_value_next  = res_value_reg;
        res_empty_next  = res_empty_reg;
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_empty_next    = m_empty_reg;
        clear_pulse     = 1'b0;
        div_start       = 1'b0;
        sq_start        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_write) begin
            if (cfg_index == REG_WINDOW_LENGTH) begin
                wl_next = cfg_data[WL_W-1:0];
            end else if (cfg_index == REG_VARIANCE_FLOOR) begin
                vf_next = cfg_data[VF_W-1:0];
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_operation)
                        OP_PUSH: begin
                            if (elem_pos_reg == EW'(NUM_PARAMS - 1)) begin
                                elem_pos_next = '0;
                                state_next    = ST_CHECK;
                            end else begin
                                elem_pos_next = elem_pos_reg + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            clear_pulse   = 1'b1;
                            count_next    = '0;
                            oldest_next   = '0;
                            nslot_next    = '0;
                            elem_pos_next = '0;
                        end
                        OP_CORR, OP_COV, OP_COUNT: begin
                            q_corr_next    = (s_operation == OP_CORR);
                            row_next       = s_row_index[EW-1:0];
                            col_next       = s_col_index[EW-1:0];
                            res_empty_next = (count_reg == '0);
                            q_stage_next   = SEL_CROSS;
                            rd_cnt_next    = '0;
                            if (s_operation == OP_COUNT) begin
                                res_value_next = RESULT_W'(count_reg);
                                state_next     = ST_OUT;
                            end else if (count_reg == '0 || !row_ok || !col_ok) begin
                                res_value_next = '0;
                                state_next     = ST_OUT;
                            end else begin
                                state_next = ST_QREAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK: begin
                k_next          = '0;
                i_next          = '0;
                j_next          = '0;
                elem_phase_next = 1'b0;
                if (count_reg != '0 && count_reg >= lim) begin
                    pass_slot_next = oldest_reg;
                    pass_neg_next  = 1'b1;
                end else begin
                    pass_slot_next = nslot_reg;
                    pass_neg_next  = 1'b0;
                end
                state_next = ST_PASS;
            end
            ST_PASS: begin
                if (!elem_phase_reg) begin
                    if (j_reg == EW'(NUM_PARAMS - 1)) begin
                        if (i_reg == EW'(NUM_PARAMS - 1)) begin
                            elem_phase_next = 1'b1;
                            i_next          = '0;
                        end else begin
                            i_next = i_reg + 1'b1;
                            j_next = i_reg + 1'b1;
                        end
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                end
                if (pass_last) begin
                    if (pass_neg_reg) begin
                        oldest_next = (oldest_reg == SW'(HISTORY_DEPTH)) ? '0
                                                                         : oldest_reg + 1'b1;
                        count_next  = count_reg - 1'b1;
                    end else begin
                        nslot_next = (nslot_reg == SW'(HISTORY_DEPTH)) ? '0
                                                                       : nslot_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = pass_neg_reg ? ST_CHECK : ST_IDLE;
                end
            end
            ST_QREAD: begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == 2'd3) begin
                    state_next = ST_QMUL;
                end
            end
            ST_QMUL: begin
                state_next = ST_QDIVGO;
            end
            ST_QDIVGO: begin
                div_start  = 1'b1;
                state_next = ST_QDIV;
            end
            ST_QDIV: begin
                if (!div_busy_reg) begin
                    rd_cnt_next = '0;
                    case (q_stage_reg)
                        SEL_CROSS: begin
                            if (q_corr_reg) begin
                                c_next       = div_q[33:0];
                                q_stage_next = SEL_ROW;
                                state_next   = ST_QREAD;
                            end else begin
                                res_value_next = q_sat;
                                state_next     = ST_OUT;
                            end
                        end
                        SEL_ROW: begin
                            vi_next      = q_floored;
                            q_stage_next = SEL_COL;
                            state_next   = ST_QREAD;
                        end
                        SEL_COL: begin
                            vj_next    = q_floored;
                            state_next = ST_CMUL;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_CMUL: begin
                state_next = ST_SQGO;
            end
            ST_SQGO: begin
                sq_start   = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                if (sq_bit_reg == '0) begin
                    d_next     = (sq_res_reg[31:0] == '0) ? 32'd1 : sq_res_reg[31:0];
                    state_next = ST_CDIVGO;
                end
            end
            ST_CDIVGO: begin
                div_start  = 1'b1;
                state_next = ST_CDIV;
            end
            ST_CDIV: begin
                if (!div_busy_reg) begin
                    res_value_next = q_corr_val;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_empty_next = res_empty_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            oldest_reg   <= '0;
            nslot_reg    <= '0;
            elem_pos_reg <= '0;
            wl_reg       <= WL_RESET;
            vf_reg       <= VF_RESET;
            m_valid_reg  <= 1'b0;
            drain_reg    <= 1'b0;
            rd_cnt_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            oldest_reg   <= oldest_next;
            nslot_reg    <= nslot_next;
            elem_pos_reg <= elem_pos_next;
            wl_reg       <= wl_next;
            vf_reg       <= vf_next;
            m_valid_reg  <= m_valid_next;
            drain_reg    <= drain_next;
            rd_cnt_reg   <= rd_cnt_next;
        end
        pass_slot_reg  <= pass_slot_next;
        pass_neg_reg   <= pass_neg_next;
        k_reg          <= k_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        elem_phase_reg <= elem_phase_next;
        q_stage_reg    <= q_stage_next;
        q_corr_reg     <= q_corr_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        c_reg          <= c_next;
        vi_reg         <= vi_next;
        vj_reg         <= vj_next;
        d_reg          <= d_next;
        res_value_reg  <= res_value_next;
        res_empty_reg  <= res_empty_next;
        m_value_reg    <= m_value_next;
        m_empty_reg    <= m_empty_next;
    end

    // ring pointers agree with the sample count
    a_ring_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) == (oldest_reg == nslot_reg))
        else $error("ring pointers and count disagree");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("window count above history depth");

    // write back never hits the entry being read in a pass
    a_no_rmw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PASS && s2_valid_reg) |-> (s2_addr_reg != k_reg))
        else $error("sums read and write back collide");

    a_idle_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!div_busy_reg && sq_bit_reg == '0))
        else $error("word accepted while arithmetic busy");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("output word loaded outside output state");

endmodule
